// ----- sv/pwmpc_pkg.sv -----
// Shared types, constants and helper functions of the PWM prescaler and period calculator.
`timescale 1ns / 1ps
package pwmpc_pkg;

    localparam longint unsigned NsNum      = 64'd256000000000;
    localparam longint unsigned StepNs     = 64'd655350;
    localparam longint unsigned MaxProduct = 64'd1792;
    localparam longint unsigned TickNs     = 64'd10;
    localparam longint unsigned DutyFull   = 64'd10000;

    localparam int FreqW  = 32;
    localparam int DutyW  = 14;
    localparam int CntW   = 16;
    localparam int ProdW  = 11;
    localparam int ScaleW = 15;
    localparam int DenW   = FreqW + ScaleW;
    localparam int RemW   = 38;
    localparam int NumPairs = 64;
    localparam int PairW  = 6;

    // Frequencies below this value make the required divisor exceed the largest product.
    localparam longint unsigned RangeLimit =
        (NsNum + MaxProduct * StepNs - 64'd1) / (MaxProduct * StepNs);

    // floor(x / 10000) by reciprocal multiplication, corrected by one compare.
    localparam int XW         = CntW + DutyW;
    localparam int RecipW     = 30;
    localparam int RecipShift = 43;
    localparam longint unsigned RecipMul = (64'd1 << RecipShift) / DutyFull;
    localparam int MulW       = XW + RecipW;

    typedef struct packed {
        logic [FreqW-1:0] frequency;
        logic [DutyW-1:0] duty_a;
        logic [DutyW-1:0] duty_b;
    } t_cmd;

    typedef struct packed {
        logic            range_error;
        logic            param_error;
        logic [2:0]      clock_div_sel;
        logic [2:0]      highspeed_div_sel;
        logic [CntW-1:0] period_count;
        logic [CntW-1:0] compare_a;
        logic [CntW-1:0] compare_b;
    } t_result;

    // Side information that travels alongside the period computation.
    typedef struct packed {
        logic             range_error;
        logic             param_error;
        logic [2:0]       clock_div_sel;
        logic [2:0]       highspeed_div_sel;
        logic [DutyW-1:0] duty_a;
        logic [DutyW-1:0] duty_b;
    } t_side;

    function automatic logic [3:0] hs_div(input logic [2:0] j);
        logic [3:0] v;
        case (j)
            3'd0: v = 4'd1;
            3'd1: v = 4'd2;
            3'd2: v = 4'd4;
            3'd3: v = 4'd6;
            3'd4: v = 4'd8;
            3'd5: v = 4'd10;
            3'd6: v = 4'd12;
            3'd7: v = 4'd14;
            default: v = 4'd1;
        endcase
        return v;
    endfunction

    // Product of the pair at scan position a: i is the upper index, j the lower.
    function automatic logic [ProdW-1:0] pair_prod(input logic [PairW-1:0] a);
        logic [ProdW-1:0] p;
        p = ProdW'(hs_div(a[2:0])) << a[5:3];
        return p;
    endfunction

    // Pairs that beat pair a: a smaller product, or the same product earlier in scan order.
    function automatic logic [NumPairs-1:0] pair_mask(input logic [PairW-1:0] a);
        logic [NumPairs-1:0] m;
        logic [ProdW-1:0]    pa;
        logic [ProdW-1:0]    pb;
        m  = '0;
        pa = pair_prod(a);
        for (int b = 0; b < NumPairs; b++) begin
            pb = pair_prod(PairW'(b));
            m[b] = (pb < pa) || ((pb == pa) && (PairW'(b) < a));
        end
        return m;
    endfunction

endpackage

// ----- sv/pwmpc_select.sv -----
// Input capture, error flags and prescaler pair selection (two pipeline stages).
`timescale 1ns / 1ps
module pwmpc_select import pwmpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_cmd             i_cmd,
    input  logic [FreqW-1:0] i_min_freq,
    output logic             o_vld,
    output t_side            o_side,
    output logic [FreqW-1:0] o_freq,
    output logic [ProdW-1:0] o_prod
);

    logic             r_vld1;
    logic [FreqW-1:0] r_freq1;
    logic [DutyW-1:0] r_da1;
    logic [DutyW-1:0] r_db1;
    logic             r_perr1;
    logic             r_rerr1;

    logic [NumPairs-1:0] w_q;
    logic [NumPairs-1:0] w_sel;
    logic [PairW-1:0]    n_idx;

    logic             r_vld2;
    t_side            r_side2;
    logic [FreqW-1:0] r_freq2;
    logic [ProdW-1:0] r_prod2;

    function automatic logic [DutyW-1:0] duty_sat(input logic [DutyW-1:0] d);
        return (64'(d) > DutyFull) ? DutyW'(DutyFull) : d;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_freq1 <= i_cmd.frequency;
        r_da1   <= duty_sat(i_cmd.duty_a);
        r_db1   <= duty_sat(i_cmd.duty_b);
        r_perr1 <= (i_cmd.frequency <= i_min_freq) || (64'(i_cmd.duty_a) > DutyFull)
                   || (64'(i_cmd.duty_b) > DutyFull);
        r_rerr1 <= 64'(i_cmd.frequency) < RangeLimit;
    end

    // A pair qualifies when its product lies strictly above the required divisor.
    for (genvar g = 0; g < NumPairs; g++) begin : g_pair
        localparam longint unsigned Prod = 64'(pair_prod(PairW'(g)));
        localparam longint unsigned Thr  = NsNum / (Prod * StepNs);
        localparam logic [NumPairs-1:0] Mask = pair_mask(PairW'(g));
        assign w_q[g]   = (Prod < MaxProduct) && (64'(r_freq1) > Thr);
        assign w_sel[g] = w_q[g] && !(|(w_q & Mask));
    end

    // At most one pair is selected; with none, the largest pair stays.
    always_comb begin
        n_idx = PairW'(NumPairs - 1);
        for (int a = 0; a < NumPairs; a++) begin
            if (w_sel[a]) begin
                n_idx = PairW'(a);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2.range_error       <= r_rerr1;
        r_side2.param_error       <= r_perr1;
        r_side2.clock_div_sel     <= n_idx[5:3];
        r_side2.highspeed_div_sel <= n_idx[2:0];
        r_side2.duty_a            <= r_da1;
        r_side2.duty_b            <= r_db1;
        r_freq2                   <= r_freq1;
        r_prod2                   <= pair_prod(n_idx);
    end

    assign o_vld  = r_vld2;
    assign o_side = r_side2;
    assign o_freq = r_freq2;
    assign o_prod = r_prod2;

endmodule

// ----- sv/pwmpc_div.sv -----
// Pipelined restoring divider: constant numerator over a variable denominator, one bit per stage.
`timescale 1ns / 1ps
module pwmpc_div import pwmpc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  t_side           i_side,
    input  logic [DenW-1:0] i_den,
    output logic            o_vld,
    output t_side           o_side,
    output logic [CntW-1:0] o_quo
);

    logic            r_vld  [CntW];
    t_side           r_side [CntW];
    logic [DenW-1:0] r_den  [CntW];
    logic [RemW-1:0] r_rem  [CntW];
    logic [CntW-1:0] r_quo  [CntW];

    for (genvar k = 0; k < CntW; k++) begin : g_stage
        localparam int Bit = CntW - 1 - k;
        logic            w_vld;
        t_side           w_side;
        logic [DenW-1:0] w_den;
        logic [RemW-1:0] w_rem;
        logic [CntW-1:0] w_quo;
        logic [63:0]     w_trial;
        logic            w_ge;
        logic [RemW-1:0] n_rem;
        logic [CntW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_den  = i_den;
            assign w_rem  = RemW'(NsNum);
            assign w_quo  = '0;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
            assign w_den  = r_den[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
        end

        always_comb begin
            w_trial = 64'(w_den) << Bit;
            w_ge    = 64'(w_rem) >= w_trial;
            n_rem   = w_ge ? (w_rem - RemW'(w_trial)) : w_rem;
            n_quo   = w_quo;
            n_quo[Bit] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= w_side;
            r_den[k]  <= w_den;
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
        end
    end

    assign o_vld  = r_vld[CntW-1];
    assign o_side = r_side[CntW-1];
    assign o_quo  = r_quo[CntW-1];

endmodule

// ----- sv/pwmpc_duty.sv -----
// Compare counts from period and duty, divided by 10000 through a reciprocal (three stages).
`timescale 1ns / 1ps
module pwmpc_duty import pwmpc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  t_side           i_side,
    input  logic [CntW-1:0] i_period,
    output logic            o_vld,
    output t_result         o_result
);

    logic            r_vld1, r_vld2, r_vld3;
    t_side           r_side1, r_side2;
    logic [CntW-1:0] r_per1, r_per2;
    logic [XW-1:0]   r_xa1, r_xb1, r_xa2, r_xb2;
    logic [MulW-1:0] r_ma2, r_mb2;
    t_result         r_out;

    logic [CntW-1:0] w_qa0, w_qb0, n_ca, n_cb;
    logic [XW-1:0]   w_ra, w_rb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side1 <= i_side;
        r_per1  <= i_period;
        r_xa1   <= XW'(i_period) * XW'(i_side.duty_a);
        r_xb1   <= XW'(i_period) * XW'(i_side.duty_b);

        r_side2 <= r_side1;
        r_per2  <= r_per1;
        r_xa2   <= r_xa1;
        r_xb2   <= r_xb1;
        r_ma2   <= MulW'(r_xa1) * MulW'(RecipW'(RecipMul));
        r_mb2   <= MulW'(r_xb1) * MulW'(RecipW'(RecipMul));
    end

    // The estimate is the true quotient or one below it.
    always_comb begin
        w_qa0 = r_ma2[RecipShift +: CntW];
        w_qb0 = r_mb2[RecipShift +: CntW];
        w_ra  = r_xa2 - XW'(w_qa0) * XW'(DutyFull);
        w_rb  = r_xb2 - XW'(w_qb0) * XW'(DutyFull);
        n_ca  = (64'(w_ra) >= DutyFull) ? (w_qa0 + 1'b1) : w_qa0;
        n_cb  = (64'(w_rb) >= DutyFull) ? (w_qb0 + 1'b1) : w_qb0;
    end

    // A range error clears every other field of the result.
    always_ff @(posedge i_clk) begin
        if (r_side2.range_error) begin
            r_out.range_error       <= 1'b1;
            r_out.param_error       <= 1'b0;
            r_out.clock_div_sel     <= '0;
            r_out.highspeed_div_sel <= '0;
            r_out.period_count      <= '0;
            r_out.compare_a         <= '0;
            r_out.compare_b         <= '0;
        end else begin
            r_out.range_error       <= 1'b0;
            r_out.param_error       <= r_side2.param_error;
            r_out.clock_div_sel     <= r_side2.clock_div_sel;
            r_out.highspeed_div_sel <= r_side2.highspeed_div_sel;
            r_out.period_count      <= r_per2;
            r_out.compare_a         <= n_ca;
            r_out.compare_b         <= n_cb;
        end
    end

    assign o_vld    = r_vld3;
    assign o_result = r_out;

endmodule

// ----- sv/pwm_prescale_period_calc.sv -----
// Top level of the PWM prescaler and period calculator.
`timescale 1ns / 1ps
// For a requested PWM frequency (UQ24.8 Hz) and two duty cycles (0.01 % steps) this block
// returns a prescaler pair (2^i, one of 1,2,4,6,8,10,12,14), a period count for a 10 ns time
// base and two compare counts. It is a fixed 22-stage pipeline: a command is taken in every
// cycle (busy is always low) and its result appears on o_result with o_valid high for one
// cycle, in command order. The receiver cannot stall the pipeline, so it must take every
// result transfer in the cycle it is shown. Two stages capture the command and pick the
// pair, one stage forms the divider denominator, sixteen stages run a restoring division
// one quotient bit at a time, and three stages produce the compare counts. Write
// min_frequency only while no command is in flight.
module pwm_prescale_period_calc import pwmpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    output logic             o_valid,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [FreqW-1:0] i_cfg_wdata
);

    logic [FreqW-1:0] r_min_freq;

    logic             w_sel_vld;
    t_side            w_sel_side;
    logic [FreqW-1:0] w_sel_freq;
    logic [ProdW-1:0] w_sel_prod;
    logic [ScaleW-1:0] w_scale;

    logic             r_vld3;
    t_side            r_side3;
    logic [DenW-1:0]  r_den3;

    logic             w_div_vld;
    t_side            w_div_side;
    logic [CntW-1:0]  w_div_quo;

    // The pipeline never stalls, so every start is a transfer.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq <= '0;
        end else if (i_cfg_we) begin
            r_min_freq <= i_cfg_wdata;
        end
    end

    pwmpc_select u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (start && !busy),
        .i_cmd      (i_cmd),
        .i_min_freq (r_min_freq),
        .o_vld      (w_sel_vld),
        .o_side     (w_sel_side),
        .o_freq     (w_sel_freq),
        .o_prod     (w_sel_prod)
    );

    // Denominator of the period division: frequency times ten times the chosen product.
    assign w_scale = ScaleW'(w_sel_prod) * ScaleW'(TickNs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= w_sel_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side3 <= w_sel_side;
        r_den3  <= DenW'(w_sel_freq) * DenW'(w_scale);
    end

    // The chosen product is strictly above the divisor, so the quotient fits in 16 bits.
    pwmpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld3),
        .i_side  (r_side3),
        .i_den   (r_den3),
        .o_vld   (w_div_vld),
        .o_side  (w_div_side),
        .o_quo   (w_div_quo)
    );

    pwmpc_duty u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_div_vld),
        .i_side   (w_div_side),
        .i_period (w_div_quo),
        .o_vld    (o_valid),
        .o_result (o_result)
    );

endmodule
